### rtl/mlex_pkg.sv
`default_nettype none

package mlex_pkg;

	localparam int NAME_CHARS_DEF = 12;
	localparam int NAME_SLOTS     = 12;
	localparam int KEYWORD_COUNT  = 7;
	localparam int KW_CHARS       = 6;
	localparam int QUEUE_DEPTH    = 4;
	localparam int LEN_W          = 4;

	typedef logic [5:0] kind_t;

	localparam kind_t K_NOT      = 6'd0;
	localparam kind_t K_NE       = 6'd1;
	localparam kind_t K_MOD      = 6'd2;
	localparam kind_t K_MOD_EQ   = 6'd3;
	localparam kind_t K_IDENT    = 6'd4;
	localparam kind_t K_NUMBER   = 6'd5;
	localparam kind_t K_AND_AND  = 6'd6;
	localparam kind_t K_LPAREN   = 6'd7;
	localparam kind_t K_RPAREN   = 6'd8;
	localparam kind_t K_STAR     = 6'd9;
	localparam kind_t K_STAR_EQ  = 6'd10;
	localparam kind_t K_PLUS     = 6'd11;
	localparam kind_t K_INC      = 6'd12;
	localparam kind_t K_PLUS_EQ  = 6'd13;
	localparam kind_t K_COMMA    = 6'd14;
	localparam kind_t K_MINUS    = 6'd15;
	localparam kind_t K_DECR     = 6'd16;
	localparam kind_t K_MINUS_EQ = 6'd17;
	localparam kind_t K_SLASH    = 6'd18;
	localparam kind_t K_SLASH_EQ = 6'd19;
	localparam kind_t K_SEMI     = 6'd20;
	localparam kind_t K_LT       = 6'd21;
	localparam kind_t K_LE       = 6'd22;
	localparam kind_t K_ASSIGN   = 6'd23;
	localparam kind_t K_EQ       = 6'd24;
	localparam kind_t K_GT       = 6'd25;
	localparam kind_t K_GE       = 6'd26;
	localparam kind_t K_LBRACK   = 6'd27;
	localparam kind_t K_RBRACK   = 6'd28;
	localparam kind_t K_EOF      = 6'd29;
	localparam kind_t K_CONST    = 6'd30;
	localparam kind_t K_LBRACE   = 6'd37;
	localparam kind_t K_OR_OR    = 6'd38;
	localparam kind_t K_RBRACE   = 6'd39;
	localparam kind_t K_ERROR    = 6'd40;

	typedef logic [2:0] err_t;

	localparam err_t ERR_NONE    = 3'd0;
	localparam err_t ERR_LONG    = 3'd1;
	localparam err_t ERR_AMP     = 3'd2;
	localparam err_t ERR_BAR     = 3'd3;
	localparam err_t ERR_INVALID = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NAME,
		ST_DEC,
		ST_ZERO,
		ST_OCT,
		ST_HEX,
		ST_OPER,
		ST_BLOCK,
		ST_STAR,
		ST_LINE
	} scan_state_t;

	typedef struct packed {
		kind_t             kind;
		logic [63:0]       head;
		logic [31:0]       tail;
		logic [LEN_W-1:0]  len;
		logic [31:0]       num;
		err_t              err;
		logic              last;
	} tok_t;

	typedef struct packed {
		logic [1:0] n;
		tok_t       first;
		tok_t       second;
	} push_t;

	// keyword text, left-aligned, zero-padded
	localparam logic [8*KW_CHARS-1:0] KW_TEXT [KEYWORD_COUNT] = '{
		{"const", 8'h00},
		{"else", 16'h0000},
		{"if", 32'h0000_0000},
		{"int", 24'h00_0000},
		"return",
		{"void", 16'h0000},
		{"while", 8'h00}
	};

	localparam logic [2:0] KW_LEN [KEYWORD_COUNT] = '{
		3'd5, 3'd4, 3'd2, 3'd3, 3'd6, 3'd4, 3'd5
	};

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (is_digit(c)) begin
			r = {1'b1, 4'(c - "0")};
		end else if (c >= "a" && c <= "f") begin
			r = {1'b1, 4'(c - "a" + 8'd10)};
		end else if (c >= "A" && c <= "F") begin
			r = {1'b1, 4'(c - "A" + 8'd10)};
		end
		return r;
	endfunction

	function automatic tok_t mk_tok(input kind_t kind, input err_t err, input logic [31:0] num);
		tok_t t;
		t      = '0;
		t.kind = kind;
		t.err  = err;
		t.num  = num;
		return t;
	endfunction

	// token for a pending operator not completed by its partner
	function automatic tok_t single_tok(input logic [7:0] p);
		tok_t t;
		unique case (p)
			"/":     t = mk_tok(K_SLASH, ERR_NONE, 32'd0);
			"!":     t = mk_tok(K_NOT, ERR_NONE, 32'd0);
			"%":     t = mk_tok(K_MOD, ERR_NONE, 32'd0);
			"*":     t = mk_tok(K_STAR, ERR_NONE, 32'd0);
			"+":     t = mk_tok(K_PLUS, ERR_NONE, 32'd0);
			"-":     t = mk_tok(K_MINUS, ERR_NONE, 32'd0);
			"<":     t = mk_tok(K_LT, ERR_NONE, 32'd0);
			"=":     t = mk_tok(K_ASSIGN, ERR_NONE, 32'd0);
			">":     t = mk_tok(K_GT, ERR_NONE, 32'd0);
			"&":     t = mk_tok(K_ERROR, ERR_AMP, 32'd0);
			"|":     t = mk_tok(K_ERROR, ERR_BAR, 32'd0);
			default: t = mk_tok(K_ERROR, ERR_INVALID, 32'd0);
		endcase
		return t;
	endfunction

	// {valid, kind} of a two-character operator
	function automatic logic [6:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
		logic [6:0] r;
		r = {1'b0, K_NOT};
		if (c == "=") begin
			unique case (p)
				"!":     r = {1'b1, K_NE};
				"%":     r = {1'b1, K_MOD_EQ};
				"*":     r = {1'b1, K_STAR_EQ};
				"+":     r = {1'b1, K_PLUS_EQ};
				"-":     r = {1'b1, K_MINUS_EQ};
				"/":     r = {1'b1, K_SLASH_EQ};
				"<":     r = {1'b1, K_LE};
				"=":     r = {1'b1, K_EQ};
				">":     r = {1'b1, K_GE};
				default: r = {1'b0, K_NOT};
			endcase
		end else if (p == "+" && c == "+") begin
			r = {1'b1, K_INC};
		end else if (p == "-" && c == "-") begin
			r = {1'b1, K_DECR};
		end else if (p == "&" && c == "&") begin
			r = {1'b1, K_AND_AND};
		end else if (p == "|" && c == "|") begin
			r = {1'b1, K_OR_OR};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/mlex_if.sv
`default_nettype none

interface mlex_src_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_file;

	modport source(output valid, output in_byte, output end_of_file, input ready);
	modport sink(input valid, input in_byte, input end_of_file, output ready);
endinterface

interface mlex_tok_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_kind;
	logic [63:0] name_head;
	logic [31:0] name_tail;
	logic [3:0]  name_length;
	logic [31:0] number_value;
	logic [2:0]  error_code;
	logic        last;

	modport source(
		output valid, output token_kind, output name_head, output name_tail,
		output name_length, output number_value, output error_code, output last,
		input ready
	);
	modport sink(
		input valid, input token_kind, input name_head, input name_tail,
		input name_length, input number_value, input error_code, input last,
		output ready
	);
endinterface

`default_nettype wire

### rtl/mini_c_lexer.sv
`default_nettype none

// Channel  Modport  Carries                                        Transfer
// src      sink     in_byte, end_of_file                           one source byte or end mark
// tok      source   token_kind, name_head/tail/length,             one token, last marks the
//                   number_value, error_code, last                 final token of a byte
//
// One byte per cycle sustained while the queue has room. A byte is held in the input
// register, scanned combinationally and its zero, one or two tokens written to a 4-entry
// result queue, which offers them on tok from its registers; a scan waits for queue room.
// A byte that yields two tokens needs two token transfers, so the output side sets the pace.
// src stalls only while the queue has fewer than two free entries.
// arst_n clears scanner state and queue at once; no clearing pass, ready after reset.

module mini_c_lexer #(
	parameter int NAME_CHARS = mlex_pkg::NAME_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mlex_src_if.sink   src,
	mlex_tok_if.source tok
);
	import mlex_pkg::*;

	// results of one scan step, handed to the queue
	push_t push;
	// queue can take a full step's results
	logic  room;

	// input register plus combinational scan step
	mlex_scan #(
		.NAME_CHARS(NAME_CHARS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.room   (room),
		.push   (push)
	);

	// result queue drives the token channel from registers
	mlex_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.tok    (tok)
	);

endmodule

`default_nettype wire

### rtl/mlex_scan.sv
`default_nettype none

module mlex_scan #(
	parameter int NAME_CHARS = mlex_pkg::NAME_CHARS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	mlex_src_if.sink        src,
	input  logic            room,
	output mlex_pkg::push_t push
);
	import mlex_pkg::*;

	localparam int CW = $clog2(NAME_CHARS + 1);
	localparam int IW = $clog2(NAME_CHARS);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       fire;

	// scanner state
	scan_state_t   state_q, nxt_state;
	logic [CW-1:0] cnt_q, nxt_cnt;
	logic [31:0]   acc_q, nxt_acc;
	logic [7:0]    pend_q, nxt_pend;
	logic [7:0]    name_buf_q [NAME_CHARS];

	logic          buf_we;
	logic [IW-1:0] buf_idx;
	logic [7:0]    buf_data;

	logic [7:0]    name_pad [NAME_SLOTS];
	logic [8*NAME_SLOTS-1:0] name_all;
	logic          kw_hit;
	logic [2:0]    kw_idx;
	err_t          name_err;
	tok_t          name_tok;
	tok_t          num_tok;

	// start of a token
	scan_state_t   st_state;
	logic          st_emit;
	tok_t          st_tok;
	logic          st_name;
	logic          st_acc_ld;
	logic [31:0]   st_acc;
	logic          st_pend;

	logic          a_vld, b_vld, rescan;
	tok_t          res_a, res_b;
	logic [6:0]    pk;
	logic [4:0]    hv;
	logic [7:0]    c;

	assign c         = byte_s1;
	assign fire      = valid_s1 && room;
	assign src.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.valid && src.ready) begin
			byte_s1 <= src.in_byte;
			eof_s1  <= src.end_of_file;
		end
	end

	// kept characters, zero beyond the current length
	always_comb begin
		for (int i = 0; i < NAME_SLOTS; i++) begin
			name_pad[i] = 8'h00;
		end
		for (int i = 0; i < NAME_CHARS; i++) begin
			if (CW'(i) < cnt_q) begin
				name_pad[i] = name_buf_q[IW'(i)];
			end
		end
		for (int i = 0; i < NAME_SLOTS; i++) begin
			name_all[8*(NAME_SLOTS-i)-1 -: 8] = name_pad[i];
		end
	end

	always_comb begin
		logic match;
		kw_hit = 1'b0;
		kw_idx = 3'd0;
		for (int k = 0; k < KEYWORD_COUNT; k++) begin
			match = (LEN_W'(cnt_q) == LEN_W'(KW_LEN[k]));
			for (int i = 0; i < KW_CHARS; i++) begin
				if (3'(i) < KW_LEN[k] && name_pad[i] != KW_TEXT[k][8*(KW_CHARS-i)-1 -: 8]) begin
					match = 1'b0;
				end
			end
			if (match && !kw_hit) begin
				kw_hit = 1'b1;
				kw_idx = 3'(k);
			end
		end
	end

	assign name_err = (cnt_q == CW'(NAME_CHARS)) ? ERR_LONG : ERR_NONE;
	assign num_tok  = mk_tok(K_NUMBER, ERR_NONE, acc_q);

	always_comb begin
		if (kw_hit) begin
			name_tok = mk_tok(K_CONST + kind_t'(kw_idx), name_err, 32'd0);
		end else begin
			name_tok      = mk_tok(K_IDENT, name_err, 32'd0);
			name_tok.head = name_all[8*NAME_SLOTS-1 -: 64];
			name_tok.tail = name_all[31:0];
			name_tok.len  = LEN_W'(cnt_q);
		end
	end

	// classify the byte as the first character of a token
	always_comb begin
		st_state  = ST_IDLE;
		st_emit   = 1'b0;
		st_tok    = mk_tok(K_ERROR, ERR_INVALID, 32'd0);
		st_name   = 1'b0;
		st_acc_ld = 1'b0;
		st_acc    = 32'(c - "0");
		st_pend   = 1'b0;
		priority if (is_blank(c)) begin
			st_state = ST_IDLE;
		end else if (is_letter(c)) begin
			st_state = ST_NAME;
			st_name  = 1'b1;
		end else if (is_digit(c)) begin
			st_state  = (c == "0") ? ST_ZERO : ST_DEC;
			st_acc_ld = 1'b1;
		end else begin
			unique case (c)
				"/", "!", "%", "&", "*", "+", "-", "<", "=", ">", "|": begin
					st_state = ST_OPER;
					st_pend  = 1'b1;
				end
				"(": begin st_emit = 1'b1; st_tok = mk_tok(K_LPAREN, ERR_NONE, 32'd0); end
				")": begin st_emit = 1'b1; st_tok = mk_tok(K_RPAREN, ERR_NONE, 32'd0); end
				",": begin st_emit = 1'b1; st_tok = mk_tok(K_COMMA, ERR_NONE, 32'd0); end
				";": begin st_emit = 1'b1; st_tok = mk_tok(K_SEMI, ERR_NONE, 32'd0); end
				"[": begin st_emit = 1'b1; st_tok = mk_tok(K_LBRACK, ERR_NONE, 32'd0); end
				"]": begin st_emit = 1'b1; st_tok = mk_tok(K_RBRACK, ERR_NONE, 32'd0); end
				"{": begin st_emit = 1'b1; st_tok = mk_tok(K_LBRACE, ERR_NONE, 32'd0); end
				"}": begin st_emit = 1'b1; st_tok = mk_tok(K_RBRACE, ERR_NONE, 32'd0); end
				default: begin
					st_emit = 1'b1;
					st_tok  = mk_tok(K_ERROR, ERR_INVALID, 32'd0);
				end
			endcase
		end
	end

	// one scan step: close or extend the pending token, then restart on the byte; at end of file close it and add K_EOF
	always_comb begin
		nxt_state = state_q;
		nxt_cnt   = cnt_q;
		nxt_acc   = acc_q;
		nxt_pend  = pend_q;
		buf_we    = 1'b0;
		buf_idx   = cnt_q[IW-1:0];
		buf_data  = c;
		a_vld     = 1'b0;
		res_a     = num_tok;
		b_vld     = 1'b0;
		res_b     = st_tok;
		rescan    = 1'b0;
		pk        = pair_kind(pend_q, c);
		hv        = hex_val(c);
		if (eof_s1) begin
			unique case (state_q)
				ST_NAME: begin
					a_vld = 1'b1;
					res_a = name_tok;
				end
				ST_DEC, ST_ZERO, ST_OCT, ST_HEX: begin
					a_vld = 1'b1;
					res_a = num_tok;
				end
				ST_OPER: begin
					a_vld = 1'b1;
					res_a = single_tok(pend_q);
				end
				default: ;
			endcase
			b_vld     = 1'b1;
			res_b     = mk_tok(K_EOF, ERR_NONE, 32'd0);
			nxt_state = ST_IDLE;
		end else begin
			unique case (state_q)
				ST_NAME: begin
					if (is_letter(c) || is_digit(c)) begin
						if (cnt_q < CW'(NAME_CHARS)) begin
							buf_we  = 1'b1;
							nxt_cnt = cnt_q + CW'(1);
						end
					end else begin
						a_vld  = 1'b1;
						res_a  = name_tok;
						rescan = 1'b1;
					end
				end
				ST_DEC: begin
					if (is_digit(c)) begin
						nxt_acc = acc_q * 32'd10 + 32'(c - "0");
					end else begin
						a_vld  = 1'b1;
						rescan = 1'b1;
					end
				end
				ST_ZERO: begin
					if (c >= "0" && c <= "7") begin
						nxt_acc   = 32'(c - "0");
						nxt_state = ST_OCT;
					end else if (c == "x" || c == "X") begin
						nxt_acc   = 32'd0;
						nxt_state = ST_HEX;
					end else begin
						a_vld  = 1'b1;
						rescan = 1'b1;
					end
				end
				ST_OCT: begin
					if (c >= "0" && c <= "7") begin
						nxt_acc = {acc_q[28:0], c[2:0]};
					end else begin
						a_vld  = 1'b1;
						rescan = 1'b1;
					end
				end
				ST_HEX: begin
					if (hv[4]) begin
						nxt_acc = {acc_q[27:0], hv[3:0]};
					end else begin
						a_vld  = 1'b1;
						rescan = 1'b1;
					end
				end
				ST_OPER: begin
					if (pend_q == "/" && c == "*") begin
						nxt_state = ST_BLOCK;
					end else if (pend_q == "/" && c == "/") begin
						nxt_state = ST_LINE;
					end else if (pk[6]) begin
						a_vld     = 1'b1;
						res_a     = mk_tok(pk[5:0], ERR_NONE, 32'd0);
						nxt_state = ST_IDLE;
					end else begin
						a_vld  = 1'b1;
						res_a  = single_tok(pend_q);
						rescan = 1'b1;
					end
				end
				ST_BLOCK: begin
					if (c == "*") begin
						nxt_state = ST_STAR;
					end
				end
				ST_STAR: begin
					if (c == "/") begin
						nxt_state = ST_IDLE;
					end else if (c != "*") begin
						nxt_state = ST_BLOCK;
					end
				end
				ST_LINE: begin
					if (c == 8'h0a) begin
						nxt_state = ST_IDLE;
					end
				end
				default: begin
					rescan = 1'b1;
				end
			endcase
			if (rescan) begin
				nxt_state = st_state;
				b_vld     = st_emit;
				res_b     = st_tok;
				if (st_name) begin
					buf_we  = 1'b1;
					buf_idx = '0;
					nxt_cnt = CW'(1);
				end
				if (st_acc_ld) begin
					nxt_acc = st_acc;
				end
				if (st_pend) begin
					nxt_pend = c;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			acc_q   <= '0;
			pend_q  <= '0;
		end else if (fire) begin
			state_q <= nxt_state;
			cnt_q   <= nxt_cnt;
			acc_q   <= nxt_acc;
			pend_q  <= nxt_pend;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && buf_we) begin
			name_buf_q[buf_idx] <= buf_data;
		end
	end

	// pack up to two results in order, last flag on the final one
	always_comb begin
		push.n           = fire ? ({1'b0, a_vld} + {1'b0, b_vld}) : 2'd0;
		push.first       = a_vld ? res_a : res_b;
		push.first.last  = !(a_vld && b_vld);
		push.second      = res_b;
		push.second.last = 1'b1;
	end

`ifndef SYNTHESIS
	a_eof_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eof_s1 |=> state_q == ST_IDLE)
		else $error("scanner not idle after end of file");

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NAME_CHARS))
		else $error("name count beyond kept characters");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		!room |-> push.n == 2'd0)
		else $error("results pushed without queue room");
`endif

endmodule

`default_nettype wire

### rtl/mlex_queue.sv
`default_nettype none

module mlex_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  mlex_pkg::push_t push,
	output logic            room,
	mlex_tok_if.source      tok
);
	import mlex_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int QW = $clog2(QUEUE_DEPTH + 1);

	tok_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [QW-1:0] cnt_q;
	logic          pop;
	tok_t          head;

	assign pop  = tok.valid && tok.ready;
	// a step may push two results
	assign room = cnt_q <= QW'(QUEUE_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(push.n);
			rp_q  <= rp_q + PW'(pop);
			cnt_q <= cnt_q + QW'(push.n) - QW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.first;
		end
		if (push.n == 2'd2) begin
			mem_q[wp_q + PW'(1)] <= push.second;
		end
	end

	assign head             = mem_q[rp_q];
	assign tok.valid        = cnt_q != '0;
	assign tok.token_kind   = head.kind;
	assign tok.name_head    = head.head;
	assign tok.name_tail    = head.tail;
	assign tok.name_length  = head.len;
	assign tok.number_value = head.num;
	assign tok.error_code   = head.err;
	assign tok.last         = head.last;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QW'(QUEUE_DEPTH))
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> ({1'b0, cnt_q} + (QW+1)'(push.n)) <= (QW+1)'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd0 && !pop |=> $stable(cnt_q))
		else $error("queue count moved without transfer");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mlex_pkg::*;

	localparam int NAME_LIMIT   = NAME_CHARS_DEF;
	localparam int N_DIRECTED   = 25;
	localparam int RANDOM_ITEMS = 700;

	// One source transfer as the sender offers it. Directed rows may carry a
	// hand-typed token; all other rows go through the scanner model below.
	typedef struct packed {
		logic [7:0] c;
		logic       eof;
		logic       typed;
		kind_t      want_kind;
		err_t       want_err;
	} stim_t;

	logic clk;
	logic arst_n;

	mlex_src_if src_ch ();
	mlex_tok_if tok_ch ();

	mini_c_lexer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_ch),
		.tok    (tok_ch)
	);

	// ------------------------------------------------------------------
	// Clock and reset: 4 ns period, reset held low at start and released on a falling edge.
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Limit: far beyond the slowest legal run (every byte with two tokens,
	// every gap and stall at its longest).
	initial begin
		#3_000_000;
		$display("TIMEOUT: run did not finish");
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------
	// Scanner model state
	// ------------------------------------------------------------------
	scan_state_t lex_st;
	logic [7:0]  name_buf [NAME_LIMIT];
	int unsigned name_cnt;
	logic [31:0] num_acc;
	logic [7:0]  pend_op;

	tok_t step_toks [$];   // tokens of the byte being modeled
	tok_t tokens_due [$];  // tokens the block still owes, oldest first

	string kw_words [KEYWORD_COUNT] = '{"const", "else", "if", "int", "return", "void", "while"};

	function automatic bit letter_ch(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit digit_ch(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit blank_ch(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic int hex_weight(logic [7:0] c);
		if (digit_ch(c))
			return int'(c - "0");
		if (c >= "a" && c <= "f")
			return int'(c - "a") + 10;
		if (c >= "A" && c <= "F")
			return int'(c - "A") + 10;
		return -1;
	endfunction

	function automatic void push_tok(kind_t k, logic [31:0] n, err_t e);
		tok_t t;
		t      = '0;
		t.kind = k;
		t.num  = n;
		t.err  = e;
		step_toks.push_back(t);
	endfunction

	// Close an identifier: keyword if the kept characters spell one exactly,
	// otherwise an identifier with its characters packed high-byte first.
	function automatic void push_name();
		int unsigned len;
		err_t        e;
		bit          hit;
		tok_t        t;
		len = (name_cnt < NAME_LIMIT) ? name_cnt : NAME_LIMIT;
		e   = (name_cnt >= NAME_LIMIT) ? ERR_LONG : ERR_NONE;
		for (int k = 0; k < KEYWORD_COUNT; k++) begin
			if (kw_words[k].len() == len) begin
				hit = 1'b1;
				for (int i = 0; i < len; i++)
					if (name_buf[i] != kw_words[k][i])
						hit = 1'b0;
				if (hit) begin
					push_tok(kind_t'(K_CONST + k), 32'd0, e);
					return;
				end
			end
		end
		t      = '0;
		t.kind = K_IDENT;
		t.err  = e;
		t.len  = len[LEN_W-1:0];
		for (int i = 0; i < len; i++) begin
			if (i < 8)
				t.head[63-8*i -: 8] = name_buf[i];
			else
				t.tail[31-8*(i-8) -: 8] = name_buf[i];
		end
		step_toks.push_back(t);
	endfunction

	// Pending operator that its next byte did not complete.
	function automatic void push_single(logic [7:0] p);
		case (p)
			"/":     push_tok(K_SLASH, 32'd0, ERR_NONE);
			"!":     push_tok(K_NOT, 32'd0, ERR_NONE);
			"%":     push_tok(K_MOD, 32'd0, ERR_NONE);
			"*":     push_tok(K_STAR, 32'd0, ERR_NONE);
			"+":     push_tok(K_PLUS, 32'd0, ERR_NONE);
			"-":     push_tok(K_MINUS, 32'd0, ERR_NONE);
			"<":     push_tok(K_LT, 32'd0, ERR_NONE);
			"=":     push_tok(K_ASSIGN, 32'd0, ERR_NONE);
			">":     push_tok(K_GT, 32'd0, ERR_NONE);
			"&":     push_tok(K_ERROR, 32'd0, ERR_AMP);
			"|":     push_tok(K_ERROR, 32'd0, ERR_BAR);
			default: push_tok(K_ERROR, 32'd0, ERR_INVALID);
		endcase
	endfunction

	function automatic int pair_of(logic [7:0] p, logic [7:0] c);
		if (c == "=") begin
			case (p)
				"!":     return K_NE;
				"%":     return K_MOD_EQ;
				"*":     return K_STAR_EQ;
				"+":     return K_PLUS_EQ;
				"-":     return K_MINUS_EQ;
				"/":     return K_SLASH_EQ;
				"<":     return K_LE;
				"=":     return K_EQ;
				">":     return K_GE;
				default: return -1;
			endcase
		end
		if (p == "+" && c == "+")
			return K_INC;
		if (p == "-" && c == "-")
			return K_DECR;
		if (p == "&" && c == "&")
			return K_AND_AND;
		if (p == "|" && c == "|")
			return K_OR_OR;
		return -1;
	endfunction

	// Byte seen while idle between tokens.
	function automatic void lex_start(logic [7:0] c);
		if (blank_ch(c))
			return;
		if (letter_ch(c)) begin
			name_buf[0] = c;
			name_cnt    = 1;
			lex_st      = ST_NAME;
			return;
		end
		if (digit_ch(c)) begin
			num_acc = 32'(c - "0");
			lex_st  = (c == "0") ? ST_ZERO : ST_DEC;
			return;
		end
		case (c)
			"/", "!", "%", "&", "*", "+", "-", "<", "=", ">", "|": begin
				pend_op = c;
				lex_st  = ST_OPER;
			end
			"(":     push_tok(K_LPAREN, 32'd0, ERR_NONE);
			")":     push_tok(K_RPAREN, 32'd0, ERR_NONE);
			",":     push_tok(K_COMMA, 32'd0, ERR_NONE);
			";":     push_tok(K_SEMI, 32'd0, ERR_NONE);
			"[":     push_tok(K_LBRACK, 32'd0, ERR_NONE);
			"]":     push_tok(K_RBRACK, 32'd0, ERR_NONE);
			"{":     push_tok(K_LBRACE, 32'd0, ERR_NONE);
			"}":     push_tok(K_RBRACE, 32'd0, ERR_NONE);
			default: push_tok(K_ERROR, 32'd0, ERR_INVALID);
		endcase
	endfunction

	// Advance the scanner by one byte; returns 1 when the byte ended a token
	// without belonging to it and must be scanned again from idle.
	function automatic bit lex_feed(logic [7:0] c);
		int v;
		case (lex_st)
			ST_NAME: begin
				if (letter_ch(c) || digit_ch(c)) begin
					if (name_cnt < NAME_LIMIT) begin
						name_buf[name_cnt] = c;
						name_cnt++;
					end
					return 1'b0;
				end
				push_name();
			end
			ST_DEC: begin
				if (digit_ch(c)) begin
					num_acc = num_acc * 32'd10 + 32'(c - "0");
					return 1'b0;
				end
				push_tok(K_NUMBER, num_acc, ERR_NONE);
			end
			ST_ZERO: begin
				if (c >= "0" && c <= "7") begin
					num_acc = 32'(c - "0");
					lex_st  = ST_OCT;
					return 1'b0;
				end
				if (c == "x" || c == "X") begin
					num_acc = 32'd0;
					lex_st  = ST_HEX;
					return 1'b0;
				end
				push_tok(K_NUMBER, 32'd0, ERR_NONE);
			end
			ST_OCT: begin
				if (c >= "0" && c <= "7") begin
					num_acc = num_acc * 32'd8 + 32'(c - "0");
					return 1'b0;
				end
				push_tok(K_NUMBER, num_acc, ERR_NONE);
			end
			ST_HEX: begin
				v = hex_weight(c);
				if (v >= 0) begin
					num_acc = num_acc * 32'd16 + 32'(v);
					return 1'b0;
				end
				push_tok(K_NUMBER, num_acc, ERR_NONE);
			end
			ST_OPER: begin
				if (pend_op == "/" && c == "*") begin
					lex_st = ST_BLOCK;
					return 1'b0;
				end
				if (pend_op == "/" && c == "/") begin
					lex_st = ST_LINE;
					return 1'b0;
				end
				v      = pair_of(pend_op, c);
				lex_st = ST_IDLE;
				if (v >= 0) begin
					push_tok(kind_t'(v), 32'd0, ERR_NONE);
					return 1'b0;
				end
				push_single(pend_op);
				return 1'b1;
			end
			ST_BLOCK: begin
				if (c == "*")
					lex_st = ST_STAR;
				return 1'b0;
			end
			ST_STAR: begin
				if (c == "/")
					lex_st = ST_IDLE;
				else if (c != "*")
					lex_st = ST_BLOCK;
				return 1'b0;
			end
			ST_LINE: begin
				if (c == 8'h0A)
					lex_st = ST_IDLE;
				return 1'b0;
			end
			default: begin
				lex_st = ST_IDLE;
				lex_start(c);
				return 1'b0;
			end
		endcase
		lex_st = ST_IDLE;
		return 1'b1;
	endfunction

	// Model one accepted transfer and queue the tokens it owes.
	function automatic void predict_transfer(stim_t s);
		tok_t t;
		step_toks.delete();
		if (s.eof) begin
			case (lex_st)
				ST_NAME:                         push_name();
				ST_DEC, ST_ZERO, ST_OCT, ST_HEX: push_tok(K_NUMBER, num_acc, ERR_NONE);
				ST_OPER:                         push_single(pend_op);
				default:                         ;
			endcase
			push_tok(K_EOF, 32'd0, ERR_NONE);
			lex_st = ST_IDLE;
		end else if (lex_feed(s.c)) begin
			lex_start(s.c);
		end
		// a typed row overrides the model with the single token read off by hand
		if (s.typed) begin
			t      = '0;
			t.kind = s.want_kind;
			t.err  = s.want_err;
			step_toks.delete();
			step_toks.push_back(t);
		end
		if (step_toks.size() > 0)
			step_toks[step_toks.size()-1].last = 1'b1;
		foreach (step_toks[i])
			tokens_due.push_back(step_toks[i]);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	stim_t stim_items [$];

	// Directed opener: extremes of the byte, lone ampersand and bar, zero
	// followed by a non-octal digit, hex prefix without digits, end of file
	// inside a block comment and right after a keyword.
	stim_t directed_rows [N_DIRECTED] = '{
		'{"(",   1'b0, 1'b1, K_LPAREN, ERR_NONE},
		'{8'h00, 1'b0, 1'b1, K_ERROR,  ERR_INVALID},
		'{8'hFF, 1'b0, 1'b1, K_ERROR,  ERR_INVALID},
		'{"&",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{" ",   1'b0, 1'b1, K_ERROR,  ERR_AMP},
		'{"|",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{"}",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{"0",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{"8",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{"9",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{";",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{"0",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{"X",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{")",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{"/",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{"*",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{"x",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{8'h55, 1'b1, 1'b1, K_EOF,    ERR_NONE},
		'{"i",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{"f",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{8'hAA, 1'b1, 1'b0, K_NOT,    ERR_NONE},
		'{"!",   1'b0, 1'b0, K_NOT,    ERR_NONE},
		'{"=",   1'b0, 1'b1, K_NE,     ERR_NONE},
		'{8'h7F, 1'b0, 1'b1, K_ERROR,  ERR_INVALID},
		'{"_",   1'b0, 1'b0, K_NOT,    ERR_NONE}
	};

	localparam string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	localparam string ALNUM   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

	function automatic logic [7:0] pick_from(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic void add_byte(logic [7:0] c);
		stim_t s;
		s   = '0;
		s.c = c;
		stim_items.push_back(s);
	endfunction

	function automatic void add_eof();
		stim_t s;
		s     = '0;
		s.c   = 8'($urandom_range(0, 255));   // ignored by the block
		s.eof = 1'b1;
		stim_items.push_back(s);
	endfunction

	// Mostly well-formed lexemes with random content, plus noise and comments
	// broken off by end of file.
	function automatic void build_random(int unsigned target);
		int unsigned pick;
		int unsigned n;
		string       kw;
		while (stim_items.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 22) begin
				// identifier; one in eight runs from one short of the kept length to past it
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(NAME_LIMIT - 1, NAME_LIMIT + 5)
				                                : $urandom_range(1, 8);
				add_byte(pick_from(LETTERS));
				repeat (n - 1) add_byte(pick_from(ALNUM));
			end else if (pick < 30) begin
				kw = kw_words[$urandom_range(0, KEYWORD_COUNT - 1)];
				for (int i = 0; i < kw.len(); i++)
					add_byte(kw[i]);
				if ($urandom_range(0, 3) == 0)
					add_byte(pick_from(ALNUM));
			end else if (pick < 42) begin
				// decimal; long ones may wrap past 2^32
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
				add_byte(pick_from("123456789"));
				repeat (n - 1) add_byte(pick_from("0123456789"));
			end else if (pick < 47) begin
				add_byte("0");
				n = $urandom_range(0, 13);
				repeat (n) add_byte(pick_from("01234567"));
			end else if (pick < 54) begin
				add_byte("0");
				add_byte(pick_from("xX"));
				if ($urandom_range(0, 5) == 0) begin
					repeat ($urandom_range(8, 9)) add_byte(pick_from("fF"));
				end else begin
					n = $urandom_range(0, 9);
					repeat (n) add_byte(pick_from("0123456789abcdefABCDEF"));
				end
			end else if (pick < 72) begin
				add_byte(pick_from("!%&*+-/<=>|"));
				if ($urandom_range(0, 1))
					add_byte(pick_from("=+-&|"));
			end else if (pick < 80) begin
				add_byte(pick_from("(),;[]{}"));
			end else if (pick < 86) begin
				add_byte("/");
				add_byte("*");
				n = $urandom_range(0, 10);
				repeat (n) add_byte(pick_from("ab *x;"));
				if ($urandom_range(0, 7) == 0) begin
					add_eof();
				end else begin
					if ($urandom_range(0, 1))
						add_byte("*");
					add_byte("*");
					add_byte("/");
				end
			end else if (pick < 90) begin
				add_byte("/");
				add_byte("/");
				n = $urandom_range(0, 8);
				repeat (n) add_byte(pick_from("ab */;"));
				add_byte(8'h0A);
			end else if (pick < 95) begin
				add_byte(8'($urandom_range(0, 255)));
			end else if (pick < 98) begin
				if ($urandom_range(0, 1))
					add_byte(8'($urandom_range(128, 255)));
				else
					add_byte(pick_from("#$@`'?:.^~\\\""));
			end else begin
				add_eof();
			end
			// separator: none at all often enough to glue tokens together
			pick = $urandom_range(0, 9);
			if (pick >= 4) begin
				repeat ((pick == 9) ? 2 : 1)
					add_byte(($urandom_range(0, 5) == 0) ? 8'h20 : 8'($urandom_range(9, 13)));
			end
		end
		add_eof();
	endfunction

	// Gap length shared by both sides: mostly none, some short, a few long.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Transfer monitor: model each accepted byte, check each accepted token.
	// Both run in one process so a prediction always lands before its check.
	// ------------------------------------------------------------------
	int unsigned n_taken;
	int unsigned n_tokens;
	int unsigned n_errors;
	int unsigned n_long;
	logic [63:0] kinds_seen;

	initial begin
		n_taken    = 0;
		n_tokens   = 0;
		n_errors   = 0;
		n_long     = 0;
		kinds_seen = '0;
		lex_st     = ST_IDLE;
		name_cnt   = 0;
		num_acc    = '0;
		pend_op    = '0;
		foreach (name_buf[i])
			name_buf[i] = '0;
	end

	always @(posedge clk) begin
		tok_t got;
		tok_t want;
		if (arst_n) begin
			if (src_ch.valid && src_ch.ready) begin
				predict_transfer(stim_items[n_taken]);
				n_taken++;
			end
			if (tok_ch.valid && tok_ch.ready) begin
				got.kind = tok_ch.token_kind;
				got.head = tok_ch.name_head;
				got.tail = tok_ch.name_tail;
				got.len  = tok_ch.name_length;
				got.num  = tok_ch.number_value;
				got.err  = tok_ch.error_code;
				got.last = tok_ch.last;
				kinds_seen[got.kind] = 1'b1;
				if (got.err == ERR_LONG)
					n_long++;
				if (tokens_due.size() == 0) begin
					if (n_errors < 10)
						$display("ERROR @%0t: token %0d kind=%0d arrived with none expected",
						         $realtime, n_tokens, got.kind);
					n_errors++;
				end else begin
					want = tokens_due.pop_front();
					if (got !== want) begin
						if (n_errors < 10) begin
							$display("ERROR @%0t: token %0d mismatch", $realtime, n_tokens);
							$display("  exp kind=%0d head=%h tail=%h len=%0d num=%h err=%0d last=%b",
							         want.kind, want.head, want.tail, want.len, want.num,
							         want.err, want.last);
							$display("  got kind=%0d head=%h tail=%h len=%0d num=%h err=%0d last=%b",
							         got.kind, got.head, got.tail, got.len, got.num,
							         got.err, got.last);
						end
						n_errors++;
					end
				end
				n_tokens++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Token receiver: random stalls, one calm window, and one long hold-off
	// while the sender keeps offering bytes, so the result queue fills and
	// the block backs up its input.
	// ------------------------------------------------------------------
	initial begin
		bit          held;
		int unsigned stall;
		held         = 1'b0;
		tok_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held && n_tokens >= 60) begin
				held         = 1'b1;
				tok_ch.ready = 1'b0;
				repeat (200) @(negedge clk);
			end else if (n_tokens >= 90 && n_tokens < 110) begin
				tok_ch.ready = 1'b1;
				@(negedge clk);
			end else begin
				stall = idle_len();
				if (stall > 0) begin
					tok_ch.ready = 1'b0;
					repeat (stall) @(negedge clk);
				end
				tok_ch.ready = 1'b1;
				@(negedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Byte sender, then drain and verdict.
	// ------------------------------------------------------------------
	initial begin
		int unsigned gap;
		int unsigned wait_cycles;
		src_ch.valid       = 1'b0;
		src_ch.in_byte     = 8'h00;
		src_ch.end_of_file = 1'b0;

		foreach (directed_rows[i])
			stim_items.push_back(directed_rows[i]);
		build_random(N_DIRECTED + RANDOM_ITEMS);

		@(posedge arst_n);
		@(negedge clk);
		for (int i = 0; i < stim_items.size(); i++) begin
			// once mid-run: drop valid and wait until every owed token is out
			if (i == N_DIRECTED + 420) begin
				src_ch.valid = 1'b0;
				while (tokens_due.size() != 0)
					@(posedge clk);
				@(negedge clk);
			end
			// a stretch of bytes offered back to back with no sender gaps at all
			gap = (i >= N_DIRECTED + 250 && i < N_DIRECTED + 330) ? 0 : idle_len();
			if (gap > 0) begin
				src_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			src_ch.valid       = 1'b1;
			src_ch.in_byte     = stim_items[i].c;
			src_ch.end_of_file = stim_items[i].eof;
			// hold the byte until it transfers
			do
				@(posedge clk);
			while (!src_ch.ready);
			@(negedge clk);
		end
		src_ch.valid = 1'b0;

		// drain: wait for the owed tokens through the receiver's stalls, bounded
		wait_cycles = 0;
		while (tokens_due.size() != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (8) @(posedge clk);
		if (tokens_due.size() != 0) begin
			$display("ERROR: %0d expected tokens never arrived", tokens_due.size());
			n_errors += tokens_due.size();
		end

		$display("Covered: %0d source transfers, %0d tokens checked, %0d distinct kinds,",
		         n_taken, n_tokens, $countones(kinds_seen));
		$display("  %0d over-long names; %0d errors", n_long, n_errors);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### files.f
rtl/mlex_pkg.sv
rtl/mlex_if.sv
rtl/mlex_scan.sv
rtl/mlex_queue.sv
rtl/mini_c_lexer.sv
tb/testbench.sv
